/* rtl/life_grid_generation_engine_macros.svh */
// Assertion macros for the Life grid engine
`ifndef LIFE_GRID_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_MACROS_SVH

// same-cycle implication
`define LGGE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LGGE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lgge_pkg.sv */
// Shared types and constants for the Life grid engine
package lgge_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int SIZE_W = 7;
	localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RMW,
		ST_READ,
		ST_ADV_LOAD,
		ST_ADV_ROW,
		ST_RESP
	} state_t;

endpackage

/* rtl/life_grid_generation_engine.sv */
// Top level of the Life grid engine: grid memory, sequencer and result register
// Write and read pass through the grid memory to the result register; a flagged word or
// an unused action goes straight to the result, an advance walks the rows in use first.
// One word at a time; an advance walks the grid memory one row per cycle, reading row r+2
// while row r is written. Asynchronous active-low reset; afterwards a clearing pass
// zeroes the grid memory, no words accepted until it ends.
`include "life_grid_generation_engine_macros.svh"

module life_grid_generation_engine #(
	parameter int MAX_ROWS = lgge_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lgge_pkg::MAX_COLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lgge_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgge_pkg::SIZE_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      action,
	input  logic [5:0]                      row,
	input  logic [5:0]                      col,
	input  logic                            alive,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            cell_state,
	output logic                            bad_position
);

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SW = lgge_pkg::SIZE_W;

	lgge_pkg::state_t state_q, state_d;

	logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rd_q;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [MAX_COLS-1:0] wdata;
	logic                mem_we;

	logic [SW-1:0] grid_rows_q, grid_cols_q;
	logic [SW-1:0] rows_use, cols_use;
	logic [MAX_COLS-1:0] col_mask;

	logic [1:0] act_q;
	logic [5:0] row_q, col_q;
	logic       alive_q;

	logic [AW-1:0]       clr_q;
	logic [SW-1:0]       adv_r_q;
	logic [MAX_COLS-1:0] prior_q, cur_q;
	logic [MAX_COLS-1:0] below, new_row, bit_sel;
	logic                below_ok, last_row;

	logic res_state_q, res_bad_q;
	logic out_valid_q, cell_state_q, bad_position_q;
	logic out_free, out_load;
	logic in_accept, pos_bad;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= lgge_pkg::GRID_SIZE_RESET;
			grid_cols_q <= lgge_pkg::GRID_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lgge_pkg::CFG_GRID_ROWS: grid_rows_q <= cfg_data;
				lgge_pkg::CFG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows_use = (int'(grid_rows_q) > MAX_ROWS) ? SW'(MAX_ROWS) : grid_rows_q;
	assign cols_use = (int'(grid_cols_q) > MAX_COLS) ? SW'(MAX_COLS) : grid_cols_q;

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++)
			col_mask[c] = (c < int'(cols_use));
	end

	// handshake
	assign in_stall  = (state_q != lgge_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign pos_bad   = !({1'b0, row} < rows_use) || !({1'b0, col} < cols_use);

	assign below_ok = (int'(adv_r_q) + 1) < int'(rows_use);
	assign last_row = !below_ok;
	assign below    = below_ok ? (rd_q & col_mask) : '0;

	always_comb begin
		bit_sel = '0;
		bit_sel[CB'(col_q)] = 1'b1;
	end

	lgge_row_next #(
		.COLS(MAX_COLS)
	) u_row_next (
		.prior    (prior_q),
		.cur      (cur_q),
		.below    (below),
		.mask     (col_mask),
		.next_row (new_row)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lgge_pkg::ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		waddr    = AW'(row_q);
		wdata    = '0;
		raddr    = AW'(row_q);
		out_load = 1'b0;
		case (state_q)
			lgge_pkg::ST_INIT: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				if (clr_q == AW'(MAX_ROWS - 1))
					state_d = lgge_pkg::ST_IDLE;
			end
			lgge_pkg::ST_IDLE: begin
				raddr = (action == lgge_pkg::ACT_ADVANCE) ? '0 : AW'(row);
				if (in_accept) begin
					case (action)
						lgge_pkg::ACT_WRITE:
							state_d = pos_bad ? lgge_pkg::ST_RESP : lgge_pkg::ST_RMW;
						lgge_pkg::ACT_READ:
							state_d = pos_bad ? lgge_pkg::ST_RESP : lgge_pkg::ST_READ;
						lgge_pkg::ACT_ADVANCE:
							state_d = (rows_use == '0) ? lgge_pkg::ST_RESP
								: lgge_pkg::ST_ADV_LOAD;
						default: state_d = lgge_pkg::ST_RESP;
					endcase
				end
			end
			lgge_pkg::ST_RMW: begin
				mem_we  = 1'b1;
				wdata   = alive_q ? (rd_q | bit_sel) : (rd_q & ~bit_sel);
				state_d = lgge_pkg::ST_RESP;
			end
			lgge_pkg::ST_READ: begin
				state_d = lgge_pkg::ST_RESP;
			end
			lgge_pkg::ST_ADV_LOAD: begin
				raddr   = AW'(1);
				state_d = lgge_pkg::ST_ADV_ROW;
			end
			lgge_pkg::ST_ADV_ROW: begin
				// write row r from copies while row r+2 is fetched
				mem_we = 1'b1;
				waddr  = AW'(adv_r_q);
				wdata  = new_row;
				raddr  = AW'(int'(adv_r_q) + 2);
				if (last_row)
					state_d = lgge_pkg::ST_RESP;
			end
			lgge_pkg::ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = lgge_pkg::ST_IDLE;
				end
			end
			default: state_d = lgge_pkg::ST_IDLE;
		endcase
	end

	// grid memory
	always_ff @(posedge clk) begin
		if (mem_we)
			grid_mem[waddr] <= wdata;
		rd_q <= grid_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (state_q == lgge_pkg::ST_INIT)
			clr_q <= clr_q + AW'(1);
	end

	// item and advance datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lgge_pkg::ST_IDLE: begin
				if (in_accept) begin
					act_q       <= action;
					row_q       <= row;
					col_q       <= col;
					alive_q     <= alive;
					res_state_q <= 1'b0;
					res_bad_q   <= pos_bad
						&& (action inside {lgge_pkg::ACT_WRITE, lgge_pkg::ACT_READ});
				end
			end
			lgge_pkg::ST_READ: res_state_q <= rd_q[CB'(col_q)];
			lgge_pkg::ST_ADV_LOAD: begin
				prior_q <= '0;
				cur_q   <= rd_q;
				adv_r_q <= '0;
			end
			lgge_pkg::ST_ADV_ROW: begin
				prior_q <= cur_q & col_mask;
				cur_q   <= rd_q;
				adv_r_q <= adv_r_q + SW'(1);
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_state_q   <= res_state_q;
			bad_position_q <= res_bad_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_state   = cell_state_q;
	assign bad_position = bad_position_q;

	// checks
	`LGGE_ASSERT_NXT(a_accept_busy, clk, arst_n, in_accept, state_q != lgge_pkg::ST_IDLE,
		"accepted word did not leave idle")
	`LGGE_ASSERT_IMP(a_adv_in_range, clk, arst_n, state_q == lgge_pkg::ST_ADV_ROW,
		adv_r_q < rows_use, "advance wrote a row outside the grid in use")
	`LGGE_ASSERT_NXT(a_adv_result, clk, arst_n, out_load && (act_q == lgge_pkg::ACT_ADVANCE),
		out_valid && !cell_state && !bad_position, "advance result not clean")
	`LGGE_ASSERT_IMP(a_load_free, clk, arst_n, out_load, !out_valid_q || !out_stall,
		"result word overwritten while held")

endmodule

/* rtl/lgge_row_next.sv */
// Next-generation computation for one row under the B3/S23 rule
module lgge_row_next #(
	parameter int COLS = lgge_pkg::MAX_COLS_DEF
) (
	input  logic [COLS-1:0] prior,
	input  logic [COLS-1:0] cur,
	input  logic [COLS-1:0] below,
	input  logic [COLS-1:0] mask,
	output logic [COLS-1:0] next_row
);

	logic [COLS+1:0] p_pad;
	logic [COLS+1:0] c_pad;
	logic [COLS+1:0] b_pad;
	logic [COLS-1:0] live;

	// zero pad either side so edge columns see dead neighbours
	assign p_pad = {1'b0, prior, 1'b0};
	assign c_pad = {1'b0, cur & mask, 1'b0};
	assign b_pad = {1'b0, below, 1'b0};

	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < COLS; c++) begin
			n = 4'(p_pad[c]) + 4'(p_pad[c+1]) + 4'(p_pad[c+2])
				+ 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2])
				+ 4'(c_pad[c]) + 4'(c_pad[c+2]);
			live[c] = mask[c] & ((n == 4'd3) | (c_pad[c+1] & (n == 4'd2)));
		end
	end

	// cells outside the columns in use keep their stored bits
	assign next_row = (cur & ~mask) | live;

endmodule
